// ===== rtl/core/ibl_pkg.sv =====
// ibl_pkg: shared command codes, register indexes, widths and reset values
// for the inode block locator and its port checker. No dependencies.
`timescale 1ns / 1ps
package ibl_pkg;

  localparam int DEF_MAX_GROUPS = 256;

  localparam int CMD_W   = 2;
  localparam int INO_W   = 32;
  localparam int SLOT_W  = 8;
  localparam int BLK_W   = 32;
  localparam int OFS_W   = 12;
  localparam int IPG_W   = 16;
  localparam int RSZ_W   = 11;
  localparam int LGK_W   = 2;
  localparam int CFGI_W  = 2;
  localparam int CFGD_W  = 16;

  localparam logic [CMD_W-1:0] CMD_WRITE_GROUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOCATE      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INVALIDATE  = 2'd2;

  localparam logic [CFGI_W-1:0] REG_INODES_PER_GROUP = 2'd0;
  localparam logic [CFGI_W-1:0] REG_RECORD_SIZE      = 2'd1;
  localparam logic [CFGI_W-1:0] REG_LOG_BLOCK_KIB    = 2'd2;

  localparam logic [IPG_W-1:0] IPG_RESET = 16'd8192;
  localparam logic [RSZ_W-1:0] RSZ_RESET = 11'd128;
  localparam logic [LGK_W-1:0] LGK_RESET = 2'd0;
  localparam logic [BLK_W-1:0] NO_BLOCK  = '1;

endpackage

// ===== rtl/core/inode_block_locator.sv =====
// inode_block_locator: inode number to (block, in-block offset) locator with
// group start table and one-entry loaded-block cache. Depends on ibl_pkg.
`timescale 1ns / 1ps
//
// Channel   Ports                                        Transfer
// --------  -------------------------------------------  ------------------------
// input     start, busy, in_command, in_inode_number,      start && !busy at clk edge
//           in_group_slot, in_table_start_block
// result    out_valid, out_found, out_block_number,        out_valid, one cycle
//           out_byte_offset, out_read_needed
// config    cfg_we, cfg_index, cfg_wdata                   cfg_we at clk edge
//
// Table write, invalidate and unused commands give no result. A locate of inode
// zero is answered straight from idle, a group beyond the table after the divide
// and range check, a found inode after 32 divide steps, one range check, 11
// multiply steps and one final add; divide, multiply and add share one 32-bit adder.
// busy is high from the cycle after a locate transfer of a nonzero inode until
// its result shows.
// Reset (rst_n low, synchronous) restores the config defaults and empties the
// cache; the group table is not cleared. The receiver cannot stall results.
module inode_block_locator #(
  parameter int MAX_GROUPS = ibl_pkg::DEF_MAX_GROUPS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        start,
  output logic                        busy,
  input  logic [ibl_pkg::CMD_W-1:0]   in_command,
  input  logic [ibl_pkg::INO_W-1:0]   in_inode_number,
  input  logic [ibl_pkg::SLOT_W-1:0]  in_group_slot,
  input  logic [ibl_pkg::BLK_W-1:0]   in_table_start_block,
  // result channel
  output logic                        out_valid,
  output logic                        out_found,
  output logic [ibl_pkg::BLK_W-1:0]   out_block_number,
  output logic [ibl_pkg::OFS_W-1:0]   out_byte_offset,
  output logic                        out_read_needed,
  // config port
  input  logic                        cfg_we,
  input  logic [ibl_pkg::CFGI_W-1:0]  cfg_index,
  input  logic [ibl_pkg::CFGD_W-1:0]  cfg_wdata
);
  import ibl_pkg::*;

  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int AW = 32;              // shared adder width
  localparam int OW = IPG_W + RSZ_W;   // record offset width

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;

  localparam logic [4:0] DIV_LAST = 5'd31;
  localparam logic [4:0] MUL_LAST = 5'(RSZ_W - 1);

  // config registers
  logic [IPG_W-1:0] ipg_r;
  logic [RSZ_W-1:0] rsz_r;
  logic [LGK_W-1:0] lgk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipg_r <= IPG_RESET;
      rsz_r <= RSZ_RESET;
      lgk_r <= LGK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INODES_PER_GROUP: ipg_r <= cfg_wdata[IPG_W-1:0];
        REG_RECORD_SIZE:      rsz_r <= cfg_wdata[RSZ_W-1:0];
        REG_LOG_BLOCK_KIB:    lgk_r <= cfg_wdata[LGK_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  logic [2:0]       state_r, state_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [INO_W-1:0] q_r, q_nxt;        // dividend in, quotient out
  logic [IPG_W-1:0] rem_r, rem_nxt;    // remainder = index in group
  logic [OW-1:0]    acc_r, acc_nxt;    // record offset accumulator
  logic [RSZ_W-1:0] rs_r, rs_nxt;      // record size, MSB first
  logic [BLK_W-1:0] cache_r, cache_nxt;

  logic             ov_r, ov_nxt;
  logic             of_r, of_nxt;
  logic [BLK_W-1:0] ob_r, ob_nxt;
  logic [OFS_W-1:0] oo_r, oo_nxt;
  logic             orn_r, orn_nxt;

  // group table memory, registered read
  logic [BLK_W-1:0] gtab [MAX_GROUPS];
  logic [BLK_W-1:0] tab_rd_r;
  logic             accept;
  logic             tab_we;

  assign accept = start && (state_r == ST_IDLE);
  assign tab_we = accept && (in_command == CMD_WRITE_GROUP)
                  && (32'(in_group_slot) < 32'(MAX_GROUPS));

  always_ff @(posedge clk) begin
    if (tab_we) gtab[GW'(in_group_slot)] <= in_table_start_block;
    tab_rd_r <= gtab[q_r[GW-1:0]];
  end

  // shared add/subtract unit; carry out means no borrow on subtract
  logic [AW-1:0] add_a, add_b;
  logic          add_sub;
  logic [AW:0]   add_res;

  assign add_res = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (AW+1)'(add_sub);

  logic [IPG_W:0] rem_sh;
  logic [1:0]     lg;
  logic [3:0]     blk_sh;
  logic [OFS_W-1:0] ofs_mask;

  assign rem_sh   = {rem_r, q_r[INO_W-1]};
  assign lg       = (lgk_r > 2'd2) ? 2'd2 : lgk_r;   // code three acts as 4 KiB
  assign blk_sh   = 4'd10 + 4'(lg);
  assign ofs_mask = OFS_W'((13'd1024 << lg) - 13'd1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    rs_nxt    = rs_r;
    cache_nxt = cache_r;
    ov_nxt    = 1'b0;
    of_nxt    = of_r;
    ob_nxt    = ob_r;
    oo_nxt    = oo_r;
    orn_nxt   = orn_r;
    add_a     = '0;
    add_b     = '0;
    add_sub   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_LOCATE: begin
              if (in_inode_number == '0) begin
                ov_nxt  = 1'b1;
                of_nxt  = 1'b0;
                ob_nxt  = '0;
                oo_nxt  = '0;
                orn_nxt = 1'b0;
              end else begin
                q_nxt     = in_inode_number - 1'b1;
                rem_nxt   = '0;
                cnt_nxt   = '0;
                state_nxt = ST_DIV;
              end
            end
            CMD_INVALIDATE: cache_nxt = NO_BLOCK;
            default: ;
          endcase
        end
      end

      // restoring divide, one quotient bit per step
      ST_DIV: begin
        add_a   = AW'(rem_sh);
        add_b   = AW'(ipg_r);
        add_sub = 1'b1;
        rem_nxt = add_res[AW] ? add_res[IPG_W-1:0] : rem_sh[IPG_W-1:0];
        q_nxt   = {q_r[INO_W-2:0], add_res[AW]};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) state_nxt = ST_CHK;
      end

      // zero divisor leaves an all-ones quotient, caught here too
      ST_CHK: begin
        if (q_r >= 32'(MAX_GROUPS)) begin
          ov_nxt    = 1'b1;
          of_nxt    = 1'b0;
          ob_nxt    = '0;
          oo_nxt    = '0;
          orn_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          acc_nxt   = '0;
          rs_nxt    = rsz_r;
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end

      // shift-add multiply, record size MSB first
      ST_MUL: begin
        add_a   = AW'({acc_r[OW-2:0], 1'b0});
        add_b   = rs_r[RSZ_W-1] ? AW'(rem_r) : '0;
        acc_nxt = add_res[OW-1:0];
        rs_nxt  = {rs_r[RSZ_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == MUL_LAST) state_nxt = ST_ADD;
      end

      ST_ADD: begin
        add_a   = tab_rd_r;
        add_b   = AW'(acc_r >> blk_sh);
        ov_nxt  = 1'b1;
        of_nxt  = 1'b1;
        ob_nxt  = add_res[BLK_W-1:0];
        oo_nxt  = acc_r[OFS_W-1:0] & ofs_mask;
        orn_nxt = (add_res[BLK_W-1:0] != cache_r);
        if (add_res[BLK_W-1:0] != cache_r) cache_nxt = add_res[BLK_W-1:0];
        state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      cache_r <= NO_BLOCK;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cache_r <= cache_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    rs_r  <= rs_nxt;
    of_r  <= of_nxt;
    ob_r  <= ob_nxt;
    oo_r  <= oo_nxt;
    orn_r <= orn_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = ov_r;
  assign out_found        = of_r;
  assign out_block_number = ob_r;
  assign out_byte_offset  = oo_r;
  assign out_read_needed  = orn_r;

endmodule

// ===== rtl/core/ibl_checker.sv =====
// ibl_checker: port-level assertions for inode_block_locator, with the bind
// that attaches it. Depends on ibl_pkg and inode_block_locator.
`timescale 1ns / 1ps
module ibl_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [ibl_pkg::CMD_W-1:0]   in_command,
  input logic [ibl_pkg::INO_W-1:0]   in_inode_number,
  input logic                        out_valid,
  input logic                        out_found,
  input logic [ibl_pkg::BLK_W-1:0]   out_block_number,
  input logic [ibl_pkg::OFS_W-1:0]   out_byte_offset,
  input logic                        out_read_needed
);
  import ibl_pkg::*;

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |->
      out_block_number == '0 && out_byte_offset == '0 && !out_read_needed)
    else $error("miss result with nonzero fields");

  // inode zero answers in the next cycle as not found
  a_zero_inode: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command == CMD_LOCATE && in_inode_number == '0
      |=> out_valid && !out_found && !busy)
    else $error("inode zero not answered at once");

  // non-locate commands finish at once and give no result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command != CMD_LOCATE |=> !busy && !out_valid)
    else $error("non-locate command produced a result or stayed busy");

  // only a locate transfer makes the block busy
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start) && $past(in_command) == CMD_LOCATE)
    else $error("busy without a locate transfer");

endmodule

bind inode_block_locator ibl_checker u_ibl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_command       (in_command),
  .in_inode_number  (in_inode_number),
  .out_valid        (out_valid),
  .out_found        (out_found),
  .out_block_number (out_block_number),
  .out_byte_offset  (out_byte_offset),
  .out_read_needed  (out_read_needed)
);

// ===== test/inode_block_locator_tb.sv =====
// inode_block_locator_tb: self-checking bench for the inode block locator.
// Directed table, then constrained-by-hand random traffic over several register
// settings. Depends on ibl_pkg and the inode_block_locator RTL.
`timescale 1ns / 1ps
module inode_block_locator_tb;
  import ibl_pkg::*;

  // Command code with no function; the block must swallow it silently.
  localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
  // Register index that maps to nothing.
  localparam logic [CFGI_W-1:0] REG_SPARE  = 2'd3;

  localparam int MAX_GROUPS      = DEF_MAX_GROUPS;
  localparam int SETTLE_CYCLES   = 50;       // outlasts a found locate
  localparam int ITEMS_PER_PHASE = 210;
  localparam int NUM_PHASES      = 9;
  localparam int CYCLE_LIMIT     = 1000000;

  // One locate result as the block reports it.
  typedef struct packed {
    logic             found;
    logic [BLK_W-1:0] blk;
    logic [OFS_W-1:0] ofs;
    logic             rdn;
  } loc_result_t;

  // One row of the directed table; want is only used when typed is set.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [INO_W-1:0]  ino;
    logic [SLOT_W-1:0] slot;
    logic [BLK_W-1:0]  tsb;
    logic              typed;
    loc_result_t       want;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    in_command;
  logic [INO_W-1:0]    in_inode_number;
  logic [SLOT_W-1:0]   in_group_slot;
  logic [BLK_W-1:0]    in_table_start_block;
  logic                out_valid;
  logic                out_found;
  logic [BLK_W-1:0]    out_block_number;
  logic [OFS_W-1:0]    out_byte_offset;
  logic                out_read_needed;
  logic                cfg_we;
  logic [CFGI_W-1:0]   cfg_index;
  logic [CFGD_W-1:0]   cfg_wdata;

  inode_block_locator dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_command           (in_command),
    .in_inode_number      (in_inode_number),
    .in_group_slot        (in_group_slot),
    .in_table_start_block (in_table_start_block),
    .out_valid            (out_valid),
    .out_found            (out_found),
    .out_block_number     (out_block_number),
    .out_byte_offset      (out_byte_offset),
    .out_read_needed      (out_read_needed),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: config registers, group start table, loaded block.
  // ---------------------------------------------------------------------------
  logic [IPG_W-1:0] ipg_cfg;
  logic [RSZ_W-1:0] rsz_cfg;
  logic [LGK_W-1:0] lgk_cfg;
  logic [BLK_W-1:0] grp_start [MAX_GROUPS];
  bit               grp_written [MAX_GROUPS];
  int               written_slots [$];     // slots with a defined start block
  logic [BLK_W-1:0] cached_blk;

  loc_result_t expected_locs [$];          // locate results still owed by the block
  stim_row_t   directed_rows [$];

  int err_count;
  int cycle_count;
  int n_locates, n_found, n_reads, n_writes, n_invals, n_unused, n_settings;

  // Group of an inode; all ones when there is none (inode zero or no groups).
  function automatic logic [31:0] group_of(input logic [INO_W-1:0] ino);
    if (ino == '0 || ipg_cfg == '0)
      return '1;
    return (ino - 32'd1) / {16'd0, ipg_cfg};
  endfunction

  // Expected locate result; updates the loaded-block shadow like the block does.
  function automatic loc_result_t locate_inode(input logic [INO_W-1:0] ino);
    loc_result_t r;
    logic [31:0] grp, idx, off, mask;
    int          shamt;
    r   = '0;
    grp = group_of(ino);
    if (ino != '0 && grp < MAX_GROUPS) begin
      idx   = (ino - 32'd1) % {16'd0, ipg_cfg};
      shamt = (lgk_cfg > 2'd2) ? 2 : int'(lgk_cfg);   // code three acts as 4 KiB
      off   = idx * {21'd0, rsz_cfg};
      mask  = (32'd1024 << shamt) - 32'd1;
      r.found = 1'b1;
      r.blk   = grp_start[grp[7:0]] + (off >> (10 + shamt));
      r.ofs   = off[11:0] & mask[11:0];
      r.rdn   = (r.blk != cached_blk);
      if (r.rdn)
        cached_blk = r.blk;
    end
    return r;
  endfunction

  task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [INO_W-1:0] ino,
                         input logic [SLOT_W-1:0] slot, input logic [BLK_W-1:0] tsb,
                         input logic typed, input loc_result_t want);
    stim_row_t row;
    row.cmd   = cmd;
    row.ino   = ino;
    row.slot  = slot;
    row.tsb   = tsb;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Present one command at a falling edge and hold it until the transfer.
  // Returns at the falling edge after the transfer; start is left high.
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [INO_W-1:0] ino,
                       input logic [SLOT_W-1:0] slot, input logic [BLK_W-1:0] tsb,
                       input logic typed, input loc_result_t want);
    loc_result_t got;
    start                = 1'b1;
    in_command           = cmd;
    in_inode_number      = ino;
    in_group_slot        = slot;
    in_table_start_block = tsb;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    // Transfer happened at this edge: update the shadow in transfer order.
    case (cmd)
      CMD_WRITE_GROUP: begin
        grp_start[slot] = tsb;
        if (!grp_written[slot]) begin
          grp_written[slot] = 1'b1;
          written_slots.push_back(int'(slot));
        end
        n_writes++;
      end
      CMD_LOCATE: begin
        got = locate_inode(ino);
        expected_locs.push_back(typed ? want : got);
        n_locates++;
        if (got.found) n_found++;
        if (got.rdn)   n_reads++;
      end
      CMD_INVALIDATE: begin
        cached_blk = NO_BLOCK;
        n_invals++;
      end
      default: n_unused++;
    endcase
    @(negedge clk);
  endtask

  // Register writes only with the block idle: nothing owed, and enough cycles
  // after the last transfer that a silent command has surely finished.
  task automatic program_regs(input logic [IPG_W-1:0] ipg, input logic [RSZ_W-1:0] rsz,
                              input logic [LGK_W-1:0] lgk, input bit touch_spare);
    start = 1'b0;
    while (expected_locs.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = REG_INODES_PER_GROUP;
    cfg_wdata = ipg;
    @(negedge clk);
    cfg_index = REG_RECORD_SIZE;
    cfg_wdata = {5'd0, rsz};
    @(negedge clk);
    cfg_index = REG_LOG_BLOCK_KIB;
    cfg_wdata = {14'd0, lgk};
    @(negedge clk);
    if (touch_spare) begin
      // unmapped index: must not disturb anything
      cfg_index = REG_SPARE;
      cfg_wdata = CFGD_W'($urandom);
      @(negedge clk);
    end
    cfg_we  = 1'b0;
    ipg_cfg = ipg;
    rsz_cfg = rsz;
    lgk_cfg = lgk;
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each strobe is one transfer, compared to the oldest
  // expectation field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    loc_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_locs.size() == 0) begin
        $error("result with nothing expected: found %0d block %h offset %0d read %0d",
               out_found, out_block_number, out_byte_offset, out_read_needed);
        err_count++;
      end else begin
        exp_r = expected_locs.pop_front();
        if (out_found !== exp_r.found) begin
          $error("found: expected %0d, got %0d", exp_r.found, out_found);
          err_count++;
        end
        if (out_block_number !== exp_r.blk) begin
          $error("block_number: expected %h, got %h", exp_r.blk, out_block_number);
          err_count++;
        end
        if (out_byte_offset !== exp_r.ofs) begin
          $error("byte_offset: expected %0d, got %0d", exp_r.ofs, out_byte_offset);
          err_count++;
        end
        if (out_read_needed !== exp_r.rdn) begin
          $error("read_needed: expected %0d, got %0d", exp_r.rdn, out_read_needed);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stim
    logic [CMD_W-1:0]  cmd;
    logic [INO_W-1:0]  ino, wf_ino, last_ino;
    logic [SLOT_W-1:0] slot;
    logic [BLK_W-1:0]  tsb;
    logic [31:0]       idx, last_idx, grp;
    int                pick, gap, g;
    bit                gaps_on;

    err_count  = 0;
    cycle_count = 0;
    n_locates = 0; n_found = 0; n_reads = 0; n_writes = 0;
    n_invals  = 0; n_unused = 0; n_settings = 1;
    last_ino = 32'd1;
    last_idx = '0;

    // all inputs known from time zero
    rst_n                = 1'b0;
    start                = 1'b0;
    in_command           = CMD_WRITE_GROUP;
    in_inode_number      = '0;
    in_group_slot        = '0;
    in_table_start_block = '0;
    cfg_we               = 1'b0;
    cfg_index            = REG_INODES_PER_GROUP;
    cfg_wdata            = '0;

    // shadow reset: table entries stay undefined, cache empty
    ipg_cfg    = IPG_RESET;
    rsz_cfg    = RSZ_RESET;
    lgk_cfg    = LGK_RESET;
    cached_blk = NO_BLOCK;
    for (int s = 0; s < MAX_GROUPS; s++) begin
      grp_start[s]   = '0;
      grp_written[s] = 1'b0;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed table at reset settings: 8192 inodes/group, 128-byte records,
    // 1 KiB blocks. Typed results are the ones readable at a glance.
    add_row(CMD_LOCATE,      32'd0,       8'd0,   32'd0,        1'b1, '0);  // inode zero
    add_row(CMD_WRITE_GROUP, 32'd0,       8'd0,   32'h0000_1000, 1'b0, '0);
    add_row(CMD_WRITE_GROUP, 32'd0,       8'd255, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(CMD_WRITE_GROUP, 32'd0,       8'd1,   32'd0,        1'b0, '0);
    add_row(CMD_LOCATE,      32'd1,       8'd0,   32'd0,        1'b1,
            '{1'b1, 32'h0000_1000, 12'd0, 1'b1});                          // cold cache
    add_row(CMD_LOCATE,      32'd1,       8'd0,   32'd0,        1'b1,
            '{1'b1, 32'h0000_1000, 12'd0, 1'b0});                          // cache hit
    add_row(CMD_LOCATE,      32'd8,       8'd0,   32'd0,        1'b1,
            '{1'b1, 32'h0000_1000, 12'd896, 1'b0});                        // last record of block
    add_row(CMD_LOCATE,      32'd9,       8'd0,   32'd0,        1'b1,
            '{1'b1, 32'h0000_1001, 12'd0, 1'b1});                          // next block
    add_row(CMD_INVALIDATE,  32'd0,       8'd0,   32'd0,        1'b0, '0);
    add_row(CMD_LOCATE,      32'd9,       8'd0,   32'd0,        1'b1,
            '{1'b1, 32'h0000_1001, 12'd0, 1'b1});                          // reload after invalidate
    add_row(CMD_LOCATE,      32'd8192,    8'd0,   32'd0,        1'b1,
            '{1'b1, 32'h0000_13FF, 12'd896, 1'b1});                        // last index of group
    add_row(CMD_LOCATE,      32'd8193,    8'd0,   32'd0,        1'b1,
            '{1'b1, 32'h0000_0000, 12'd0, 1'b1});                          // first of group 1
    add_row(CMD_LOCATE,      32'd2088961, 8'd0,   32'd0,        1'b1,
            '{1'b1, 32'hFFFF_FFFF, 12'd0, 1'b1});                          // last group
    add_row(CMD_LOCATE,      32'd2097152, 8'd0,   32'd0,        1'b1,
            '{1'b1, 32'h0000_03FE, 12'd896, 1'b1});                        // block sum wraps
    add_row(CMD_LOCATE,      32'd2097153, 8'd0,   32'd0,        1'b1, '0);  // first group past table
    add_row(CMD_LOCATE,      32'hFFFF_FFFF, 8'd0, 32'd0,        1'b1, '0);  // largest inode
    add_row(CMD_UNUSED,      32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(CMD_LOCATE,      32'd2088961, 8'd0,   32'd0,        1'b1,
            '{1'b1, 32'hFFFF_FFFF, 12'd0, 1'b1});
    add_row(CMD_INVALIDATE,  32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0, '0);
    // all-ones block matches the empty-cache marker: no read reported
    add_row(CMD_LOCATE,      32'd2088961, 8'd0,   32'd0,        1'b1,
            '{1'b1, 32'hFFFF_FFFF, 12'd0, 1'b0});
    add_row(CMD_WRITE_GROUP, 32'd0,       8'd255, 32'hA5A5_5A5A, 1'b0, '0);  // overwrite
    add_row(CMD_LOCATE,      32'd2088962, 8'hFF,  32'hFFFF_FFFF, 1'b0, '0);
    add_row(CMD_WRITE_GROUP, 32'd0,       8'd128, 32'h0F0F_F0F0, 1'b0, '0);
    add_row(CMD_LOCATE,      32'd1052673, 8'd0,   32'd0,        1'b0, '0);

    foreach (directed_rows[r])
      issue(directed_rows[r].cmd, directed_rows[r].ino, directed_rows[r].slot,
            directed_rows[r].tsb, directed_rows[r].typed, directed_rows[r].want);

    // Random traffic, one register setting per phase.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: ;                                              // stay at reset values
        1: program_regs(16'd1, 11'd1024, 2'd2, 1'b0);
        2: program_regs(16'd32768, 11'd128, 2'd0, 1'b0);
        3: program_regs(16'hFFFF, 11'd2047, 2'd3, 1'b1);  // widest fields, size code three
        4: program_regs(16'd0, 11'd256, 2'd1, 1'b0);      // no inodes per group
        5, 7: program_regs(16'($urandom_range(2, 600)), 11'(4 * $urandom_range(32, 256)),
                           2'($urandom_range(0, 3)), 1'b0);
        6: program_regs(16'd37, 11'd6, 2'd1, 1'b0);       // record size not a multiple of four
        default: program_regs(IPG_RESET, RSZ_RESET, LGK_RESET, 1'b0);
      endcase

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 50 == 0)
          gaps_on = ($urandom_range(0, 3) != 0);

        // hold off until the block has answered everything
        if (i == ITEMS_PER_PHASE / 2) begin
          start = 1'b0;
          while (expected_locs.size() != 0) @(negedge clk);
        end

        if (gaps_on) begin
          pick = $urandom_range(0, 99);
          if (pick < 80)      gap = $urandom_range(0, 2);
          else if (pick < 95) gap = $urandom_range(3, 8);
          else                gap = $urandom_range(10, 60);
          if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
          end
        end

        // well-formed candidate: an inode inside a group with a defined entry
        g = written_slots[$urandom_range(0, written_slots.size() - 1)];
        if (ipg_cfg == '0) begin
          wf_ino = $urandom;
        end else begin
          case ($urandom_range(0, 4))
            0:       idx = '0;
            1:       idx = {16'd0, ipg_cfg} - 32'd1;
            2:       idx = (last_idx + 32'd1 >= {16'd0, ipg_cfg}) ? '0 : last_idx + 32'd1;
            default: idx = $urandom_range(0, int'(ipg_cfg) - 1);
          endcase
          last_idx = idx;
          wf_ino   = 32'(g) * {16'd0, ipg_cfg} + idx + 32'd1;
        end

        cmd  = CMD_LOCATE;
        ino  = wf_ino;
        slot = SLOT_W'($urandom);
        tsb  = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          cmd = CMD_WRITE_GROUP;
          if ($urandom_range(0, 3) == 0)
            tsb = 32'hFFFF_FFFF - $urandom_range(0, 4000);  // sums that wrap
          ino = $urandom;
        end else if (pick < 23) begin
          cmd = CMD_INVALIDATE;
          ino = $urandom;
        end else if (pick < 25) begin
          cmd = CMD_UNUSED;
          ino = $urandom;
        end else if (pick < 29) begin
          ino = '0;
        end else if (pick < 34) begin
          // just past the last group
          if (ipg_cfg != '0)
            ino = 32'(MAX_GROUPS) * {16'd0, ipg_cfg} + 32'($urandom_range(1, 4));
        end else if (pick < 42) begin
          ino = $urandom;
        end else if (pick < 50) begin
          ino = last_ino;
        end

        // never locate into a group whose start block was never written
        if (cmd == CMD_LOCATE) begin
          grp = group_of(ino);
          if (ino != '0 && grp < MAX_GROUPS && !grp_written[grp[7:0]])
            ino = wf_ino;
          last_ino = ino;
        end

        issue(cmd, ino, slot, tsb, 1'b0, '0);
      end
    end

    // drain, then give the block time to show anything stray
    start = 1'b0;
    while (expected_locs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d locates (%0d found, %0d needing a read), %0d table writes,",
             n_locates, n_found, n_reads, n_writes);
    $display("%0d invalidates and %0d unused commands across %0d register settings.",
             n_invals, n_unused, n_settings);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
